### design/u16u8_pkg.sv
// Shared types, constants and the UTF-8 encoder function for the UTF-16 to UTF-8 transcoder.
// Used by the front end, the job queue, the byte serializer and the top level.
// No dependencies.
package u16u8_pkg;

   localparam int unsigned UNIT_W   = 16;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SCALAR_W = 21;
   localparam int unsigned HELD_W   = 10;
   localparam int unsigned MAX_BYTES = 4;
   localparam int unsigned IDX_W    = 2;

   localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;   // 0xD800 .. 0xDBFF
   localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;   // 0xDC00 .. 0xDFFF
   localparam logic [SCALAR_W-1:0] SUPP_BASE = 21'h10000;
   localparam logic [SCALAR_W-1:0] MAX_1BYTE = 21'h7F;
   localparam logic [SCALAR_W-1:0] MAX_2BYTE = 21'h7FF;
   localparam logic [SCALAR_W-1:0] MAX_3BYTE = 21'hFFFF;
   localparam logic [BYTE_W-1:0]   LEAD_2    = 8'hC0;
   localparam logic [BYTE_W-1:0]   LEAD_3    = 8'hE0;
   localparam logic [BYTE_W-1:0]   LEAD_4    = 8'hF0;
   localparam logic [1:0]          CONT_TAG  = 2'b10;

   // One queued job: a run of one to four results caused by one input beat.
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [IDX_W-1:0]                 last_idx;
      logic                             byte_valid;
      logic                             bad;
      logic                             done;
   } job_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [IDX_W-1:0]                 last_idx;
   } enc_type;

   function automatic enc_type utf8_encode(input logic [SCALAR_W-1:0] s);
      enc_type e;
      e = '0;
      if (s <= MAX_1BYTE) begin
         e.bytes[0] = {1'b0, s[6:0]};
         e.last_idx = 2'd0;
      end else if (s <= MAX_2BYTE) begin
         e.bytes[0] = LEAD_2 | {3'b000, s[10:6]};
         e.bytes[1] = {CONT_TAG, s[5:0]};
         e.last_idx = 2'd1;
      end else if (s <= MAX_3BYTE) begin
         e.bytes[0] = LEAD_3 | {4'b0000, s[15:12]};
         e.bytes[1] = {CONT_TAG, s[11:6]};
         e.bytes[2] = {CONT_TAG, s[5:0]};
         e.last_idx = 2'd2;
      end else begin
         e.bytes[0] = LEAD_4 | {5'b00000, s[20:18]};
         e.bytes[1] = {CONT_TAG, s[17:12]};
         e.bytes[2] = {CONT_TAG, s[11:6]};
         e.bytes[3] = {CONT_TAG, s[5:0]};
         e.last_idx = 2'd3;
      end
      return e;
   endfunction

endpackage

### design/u16u8_front.sv
// Front end: takes UTF-16 beats, pairs surrogates, tracks string errors and builds jobs.
// Depends on u16u8_pkg.
module u16u8_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              beat_in,
   input  logic [u16u8_pkg::UNIT_W-1:0]      code_unit,
   input  logic                              has_unit,
   input  logic                              end_of_string,
   output logic                              job_push,
   output u16u8_pkg::job_type                job
);

   logic [u16u8_pkg::HELD_W-1:0] held_ff, held_in;
   logic                         waiting_ff, waiting_in;
   logic                         skip_ff, skip_in;
   logic                         is_high, is_low;
   logic [u16u8_pkg::SCALAR_W-1:0] scalar;
   u16u8_pkg::enc_type           enc;
   logic                         any;

   assign is_high = code_unit[15:10] == u16u8_pkg::SURR_HIGH_TAG;
   assign is_low  = code_unit[15:10] == u16u8_pkg::SURR_LOW_TAG;

   always_comb begin
      held_in    = held_ff;
      waiting_in = waiting_ff;
      skip_in    = skip_ff;
      scalar     = {5'b00000, code_unit};
      any        = 1'b0;
      job        = '0;
      if (has_unit && !skip_ff) begin
         if (waiting_ff) begin
            waiting_in = 1'b0;
            held_in    = '0;
            if (is_low) begin
               scalar = u16u8_pkg::SUPP_BASE + {1'b0, held_ff, code_unit[9:0]};
               any    = 1'b1;
               job.byte_valid = 1'b1;
            end else begin
               any     = 1'b1;
               job.bad = 1'b1;
               skip_in = 1'b1;
            end
         end else if (is_high) begin
            held_in    = code_unit[9:0];
            waiting_in = 1'b1;
         end else if (is_low) begin
            any     = 1'b1;
            job.bad = 1'b1;
            skip_in = 1'b1;
         end else begin
            any = 1'b1;
            job.byte_valid = 1'b1;
         end
      end
      enc = u16u8_pkg::utf8_encode(scalar);
      if (job.byte_valid) begin
         job.bytes    = enc.bytes;
         job.last_idx = enc.last_idx;
      end
      if (end_of_string) begin
         // A high surrogate still waiting at the end of the string is an error of its own.
         if (waiting_in && !skip_in && !any) begin
            job.bad = 1'b1;
            skip_in = 1'b1;
         end
         if (skip_in) begin
            job.bad = 1'b1;
         end
         any        = 1'b1;
         job.done   = 1'b1;
         held_in    = '0;
         waiting_in = 1'b0;
         skip_in    = 1'b0;
      end
      job_push = beat_in && any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         waiting_ff <= 1'b0;
         skip_ff    <= 1'b0;
      end else if (beat_in) begin
         held_ff    <= held_in;
         waiting_ff <= waiting_in;
         skip_ff    <= skip_in;
      end
   end

endmodule

### design/u16u8_queue.sv
// Short job queue between the front end and the byte serializer.
// Depends on u16u8_pkg.
module u16u8_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u16u8_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output u16u8_pkg::job_type head
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   u16u8_pkg::job_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = count_ff == CW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

### design/u16u8_back.sv
// Back end: walks the head job one byte per cycle, while the receiver is ready, into a registered result stage.
// Depends on u16u8_pkg.
module u16u8_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_ready,
   input  u16u8_pkg::job_type             job,
   output logic                           job_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [u16u8_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                           rsp_tlast,
   output logic [2:0]                     rsp_tuser
);

   logic [u16u8_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   logic [u16u8_pkg::BYTE_W-1:0] data_ff;
   logic                        last_ff;
   logic [2:0]                  user_ff;
   logic                        load, at_last;

   assign load    = job_ready && (!valid_ff || rsp_tready);
   assign at_last = idx_ff == job.last_idx;
   assign job_pop = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset; it is only looked at while valid is high.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= job.bytes[idx_ff];
         last_ff <= at_last;
         user_ff <= {job.done && at_last, job.bad && at_last, job.byte_valid};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

### design/utf16_to_utf8_transcoder_top.sv
// Top level of the UTF-16 to UTF-8 transcoder.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// One UTF-16 code unit enters per beat, and the block takes a new beat every cycle while the
// job queue has room. Each beat that causes results turns into one job of one to four results,
// and the output serializer sends one result per cycle while the receiver is ready, so a scalar
// of n UTF-8 bytes yields n results; ASCII text streams at one unit per cycle, multibyte text at
// one byte per cycle. An input beat's job is registered in the job queue, and its first result
// then in the output register. A high surrogate yields no result until the next unit or the
// close arrives. On an unpaired surrogate the block sends one result with bad_sequence set,
// drops the rest of that string, and marks the closing result with bad_sequence as well.
module utf16_to_utf8_transcoder_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // code_unit
   input  logic        req_tuser,    // has_unit
   input  logic        req_tlast,    // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // out_byte
   output logic [2:0]  rsp_tuser,    // byte_valid, bad_sequence, string_done
   output logic        rsp_tlast     // last_of_run
);

   u16u8_pkg::job_type push_job, head_job;
   logic push, full, pop, not_empty, beat_in;

   assign req_tready = !full;
   assign beat_in    = req_tvalid && req_tready;

   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .beat_in       (beat_in),
      .code_unit     (req_tdata),
      .has_unit      (req_tuser),
      .end_of_string (req_tlast),
      .job_push      (push),
      .job           (push_job)
   );

   u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head_job)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_ready  (not_empty),
      .job        (head_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### tb/utf16_to_utf8_transcoder_top_tb.sv
// Testbench for utf16_to_utf8_transcoder_top: drives UTF-16 strings and checks every UTF-8 beat.
// Depends on u16u8_pkg and the transcoder RTL; a behavioral predictor holds its own surrogate
// state and builds the expected byte runs for each accepted code unit.
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_top_tb;

   typedef logic [u16u8_pkg::UNIT_W-1:0] unit_type;

   localparam unit_type HIGH_FIRST = 16'hD800;
   localparam unit_type HIGH_LAST  = 16'hDBFF;
   localparam unit_type LOW_FIRST  = 16'hDC00;
   localparam unit_type LOW_LAST   = 16'hDFFF;
   localparam logic [u16u8_pkg::BYTE_W-1:0] CONT_LEAD = 8'h80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [u16u8_pkg::BYTE_W-1:0] data;
      logic                         valid;
      logic                         bad;
      logic                         done;
      logic                         last;
   } utf8_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   unit_type                     req_tdata = '0;   // code_unit
   logic                         req_tuser = 1'b0; // has_unit
   logic                         req_tlast = 1'b0; // end_of_string
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [u16u8_pkg::BYTE_W-1:0] rsp_tdata;        // out_byte
   logic [2:0]                   rsp_tuser;        // byte_valid, bad_sequence, string_done
   logic                         rsp_tlast;        // last_of_run

   // Predictor state, mirroring the block's surrogate tracking.
   logic [u16u8_pkg::HELD_W-1:0] held_bits = '0;
   logic                         high_pending = 1'b0;
   logic                         dropping = 1'b0;

   utf8_result_type utf8_expect_q[$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              units_sent = 0;
   int              tx_idle_pct = 0;
   int              rx_stall_pct = 0;
   logic            hold_active = 1'b0;
   event            hold_ev;

   utf16_to_utf8_transcoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_count, utf8_expect_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Long receiver hold-off, so the job queue fills and the input side stalls.
   always begin
      @(hold_ev);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   always @(negedge clock)
      rsp_tready <= !hold_active && ($urandom_range(99) >= rx_stall_pct);

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   function automatic utf8_result_type make_result(input logic [u16u8_pkg::BYTE_W-1:0] data,
                                                   input logic valid, input logic bad);
      utf8_result_type r;
      r = '0;
      r.data  = data;
      r.valid = valid;
      r.bad   = bad;
      return r;
   endfunction

   // Works out the result run of one accepted code-unit beat and queues it.
   task automatic predict_utf8_run(input unit_type cu, input logic has, input logic eos);
      utf8_result_type                run[u16u8_pkg::MAX_BYTES];
      int                             n;
      logic [u16u8_pkg::SCALAR_W-1:0] s;
      logic                           have_scalar;
      logic                           is_high;
      logic                           is_low;
      n = 0;
      s = '0;
      have_scalar = 1'b0;
      is_high = cu >= HIGH_FIRST && cu <= HIGH_LAST;
      is_low  = cu >= LOW_FIRST && cu <= LOW_LAST;
      if (has && !dropping) begin
         if (high_pending) begin
            high_pending = 1'b0;
            if (is_low) begin
               s = u16u8_pkg::SUPP_BASE + {held_bits, 10'b0} + (cu - LOW_FIRST);
               have_scalar = 1'b1;
            end else begin
               run[0] = make_result('0, 1'b0, 1'b1);
               n = 1;
               dropping = 1'b1;
            end
            held_bits = '0;
         end else if (is_high) begin
            held_bits = cu[u16u8_pkg::HELD_W-1:0];
            high_pending = 1'b1;
         end else if (is_low) begin
            run[0] = make_result('0, 1'b0, 1'b1);
            n = 1;
            dropping = 1'b1;
         end else begin
            s = {5'b00000, cu};
            have_scalar = 1'b1;
         end
      end
      if (have_scalar) begin
         if (s <= u16u8_pkg::MAX_1BYTE) begin
            run[0] = make_result(s[7:0], 1'b1, 1'b0);
            n = 1;
         end else if (s <= u16u8_pkg::MAX_2BYTE) begin
            run[0] = make_result(u16u8_pkg::LEAD_2 | s[10:6], 1'b1, 1'b0);
            run[1] = make_result(CONT_LEAD | s[5:0], 1'b1, 1'b0);
            n = 2;
         end else if (s <= u16u8_pkg::MAX_3BYTE) begin
            run[0] = make_result(u16u8_pkg::LEAD_3 | s[15:12], 1'b1, 1'b0);
            run[1] = make_result(CONT_LEAD | s[11:6], 1'b1, 1'b0);
            run[2] = make_result(CONT_LEAD | s[5:0], 1'b1, 1'b0);
            n = 3;
         end else begin
            run[0] = make_result(u16u8_pkg::LEAD_4 | s[20:18], 1'b1, 1'b0);
            run[1] = make_result(CONT_LEAD | s[17:12], 1'b1, 1'b0);
            run[2] = make_result(CONT_LEAD | s[11:6], 1'b1, 1'b0);
            run[3] = make_result(CONT_LEAD | s[5:0], 1'b1, 1'b0);
            n = 4;
         end
      end
      if (eos) begin
         // A high surrogate still waiting at the close is an error of its own.
         if (high_pending && !dropping && n == 0) begin
            run[0] = make_result('0, 1'b0, 1'b1);
            n = 1;
            dropping = 1'b1;
         end
         if (n == 0) begin
            run[0] = make_result('0, 1'b0, dropping);
            n = 1;
         end
         run[n-1].done = 1'b1;
         if (dropping)
            run[n-1].bad = 1'b1;
         held_bits = '0;
         high_pending = 1'b0;
         dropping = 1'b0;
      end
      if (n > 0)
         run[n-1].last = 1'b1;
      for (int i = 0; i < n; i++)
         utf8_expect_q.push_back(run[i]);
   endtask

   task automatic send_unit(input unit_type cu, input logic has, input logic eos);
      if ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(2)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = cu;
      req_tuser  = has;
      req_tlast  = eos;
      do @(posedge clock); while (!req_tready);
      predict_utf8_run(cu, has, eos);
      units_sent++;
   endtask

   always @(posedge clock) begin
      utf8_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (utf8_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: byte %02h user %03b last %b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = utf8_expect_q.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch($sformatf("out_byte %02h, expected %02h", rsp_tdata, want.data));
            if (rsp_tuser[0] !== want.valid)
               report_mismatch($sformatf("byte_valid %b, expected %b", rsp_tuser[0], want.valid));
            if (rsp_tuser[1] !== want.bad)
               report_mismatch($sformatf("bad_sequence %b, expected %b", rsp_tuser[1], want.bad));
            if (rsp_tuser[2] !== want.done)
               report_mismatch($sformatf("string_done %b, expected %b", rsp_tuser[2], want.done));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last_of_run %b, expected %b", rsp_tlast, want.last));
         end
      end
   end

   // One string of random units, mostly well formed; the close rides on the last unit or
   // comes as a separate empty beat.
   task automatic send_string(input int n_units);
      logic inline_close;
      logic is_last;
      unit_type cu;
      int pick;
      inline_close = 1'($urandom_range(1));
      for (int i = 0; i < n_units; i++) begin
         is_last = inline_close && (i == n_units - 1);
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_unit(unit_type'($urandom), 1'b0, is_last);
         end else if (pick < 30) begin
            send_unit(unit_type'($urandom_range(16'h7F)), 1'b1, is_last);
         end else if (pick < 45) begin
            send_unit(unit_type'($urandom_range(16'h7FF, 16'h80)), 1'b1, is_last);
         end else if (pick < 65) begin
            cu = unit_type'($urandom_range(16'hFFFF, 16'h800));
            if (cu[15:11] == 5'b11011)
               cu[15:12] = 4'hE;
            send_unit(cu, 1'b1, is_last);
         end else if (pick < 90) begin
            send_unit(HIGH_FIRST | unit_type'($urandom_range(10'h3FF)), 1'b1, 1'b0);
            send_unit(LOW_FIRST | unit_type'($urandom_range(10'h3FF)), 1'b1, is_last);
         end else if (pick < 95) begin
            send_unit(LOW_FIRST | unit_type'($urandom_range(10'h3FF)), 1'b1, is_last);
         end else begin
            send_unit(HIGH_FIRST | unit_type'($urandom_range(10'h3FF)), 1'b1, is_last);
         end
      end
      if (!inline_close || n_units == 0)
         send_unit(unit_type'($urandom), 1'b0, 1'b1);
   endtask

   task automatic stream_strings(input int beat_target);
      int start;
      start = units_sent;
      while (units_sent - start < beat_target)
         send_string($urandom_range(6));
   endtask

   task automatic test_directed_cases();
      tx_idle_pct = 20;
      rx_stall_pct = 20;
      send_unit(16'h0000, 1'b1, 1'b0);
      send_unit(16'h007F, 1'b1, 1'b0);
      send_unit(16'h0080, 1'b1, 1'b0);
      send_unit(16'h07FF, 1'b1, 1'b0);
      send_unit(16'h0800, 1'b1, 1'b0);
      send_unit(16'hFFFF, 1'b1, 1'b1);
      send_unit(16'h0000, 1'b0, 1'b1);   // empty string
      send_unit(16'hA5C3, 1'b0, 1'b0);   // idle beat, no result
      send_unit(HIGH_FIRST, 1'b1, 1'b0);
      send_unit(LOW_FIRST, 1'b1, 1'b0);  // smallest supplementary scalar
      send_unit(HIGH_LAST, 1'b1, 1'b0);
      send_unit(LOW_LAST, 1'b1, 1'b1);   // largest scalar, closes the string
      send_unit(LOW_FIRST, 1'b1, 1'b0);  // lone low surrogate
      send_unit(16'h0041, 1'b1, 1'b0);   // dropped
      send_unit(HIGH_FIRST, 1'b1, 1'b0); // dropped
      send_unit(16'h0000, 1'b0, 1'b1);   // close carries bad_sequence
      send_unit(16'hD801, 1'b1, 1'b0);
      send_unit(16'h0042, 1'b1, 1'b1);   // high followed by a plain unit, on the close
      send_unit(HIGH_LAST, 1'b1, 1'b0);
      send_unit(16'h5A5A, 1'b0, 1'b1);   // high surrogate left open at the close
      send_unit(HIGH_FIRST, 1'b1, 1'b0);
      send_unit(HIGH_FIRST, 1'b1, 1'b0); // two highs in a row
      send_unit(LOW_LAST, 1'b1, 1'b1);   // dropped unit that closes
      send_unit(HIGH_FIRST, 1'b1, 1'b1); // high surrogate carrying the close
      send_unit(LOW_LAST, 1'b1, 1'b1);   // lone low surrogate carrying the close
   endtask

   task automatic test_stream_no_idle();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      stream_strings(90);
   endtask

   task automatic test_stream_sender_gaps();
      tx_idle_pct = 65;
      rx_stall_pct = 0;
      stream_strings(90);
   endtask

   task automatic test_stream_receiver_stalls();
      tx_idle_pct = 0;
      rx_stall_pct = 65;
      stream_strings(90);
   endtask

   task automatic test_stream_both_idle();
      tx_idle_pct = 10;
      rx_stall_pct = 10;
      stream_strings(70);
   endtask

   task automatic test_backpressure_fill();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      -> hold_ev;
      for (int i = 0; i < 30; i++)
         send_unit(unit_type'(16'h0800 + i * 16'h0123), 1'b1, (i % 8) == 7);
      send_unit(16'h0000, 1'b0, 1'b1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_stream_no_idle();
      test_stream_sender_gaps();
      test_stream_receiver_stalls();
      test_stream_both_idle();
      test_backpressure_fill();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (utf8_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (utf8_expect_q.size() != 0)
         report_mismatch($sformatf("%0d expected beats never arrived", utf8_expect_q.size()));
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
